### sv/nvse_pkg.sv
// Package for the note volume slide envelope.
// Holds the beat and state types, slide mode codes and volume limits.
// No dependencies.
package nvse_pkg;

  localparam int unsigned VolWidth   = 7;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned NibWidth   = 4;
  localparam int unsigned ModeWidth  = 2;

  localparam logic [VolWidth-1:0] VolMax   = 7'd64;
  localparam logic [NibWidth-1:0] NibMax   = 4'hF;
  localparam logic [NibWidth-1:0] NibZero  = 4'h0;

  localparam logic CmdNoteOn = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef enum logic [ModeWidth-1:0] {
    SlideNone = 2'd0,
    SlideRise = 2'd1,
    SlideFall = 2'd2
  } slide_mode_e;

  typedef struct packed {
    logic                 command;
    logic [ByteWidth-1:0] effect_byte;
    logic [VolWidth-1:0]  start_volume;
  } item_t;

  typedef struct packed {
    logic [VolWidth-1:0]  volume;
    logic                 volume_written;
    logic [ModeWidth-1:0] slide_active;
  } result_t;

  typedef struct packed {
    logic [ByteWidth-1:0] remembered_param;
    logic [NibWidth-1:0]  slide_rate;
    logic [VolWidth-1:0]  current_volume;
    slide_mode_e          slide_mode;
  } state_t;

endpackage

### sv/nvse_if.sv
// Valid/ready channel interfaces for the note volume slide envelope.
// Depends on nvse_pkg for the field widths.
interface nvse_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [nvse_pkg::ByteWidth-1:0] effect_byte;
  logic [nvse_pkg::VolWidth-1:0]  start_volume;

  modport source (output valid, command, effect_byte, start_volume, input ready);
  modport sink   (input valid, command, effect_byte, start_volume, output ready);
endinterface

interface nvse_out_if;
  logic                           valid;
  logic                           ready;
  logic [nvse_pkg::VolWidth-1:0]  volume;
  logic                           volume_written;
  logic [nvse_pkg::ModeWidth-1:0] slide_active;

  modport source (output valid, volume, volume_written, slide_active, input ready);
  modport sink   (input valid, volume, volume_written, slide_active, output ready);
endinterface

### sv/note_volume_slide_envelope.sv
// A beat accepted on the input is held in the input register; its result is then registered in the result register.
// Throughput: one beat per cycle while the result is taken; the input register and the result register
// advance together, so input ready stays high while the result is taken.
// The state update is a single add or subtract with a clamp in nvse_step.
// Reset clears the channel state (volume 0, no slide, nothing remembered)
// and empties both registers.
module note_volume_slide_envelope (
  input  logic              clk_i,
  input  logic              rst_ni,
  nvse_in_if.sink           in_i,
  nvse_out_if.source        out_o
);

  logic              s1_valid_q;
  nvse_pkg::item_t   s1_item_q;
  logic              out_valid_q;
  nvse_pkg::result_t result_q;
  nvse_pkg::state_t  state_q;
  nvse_pkg::state_t  state_d;
  nvse_pkg::result_t result_d;
  logic              advance;
  logic              in_fire;

  // The held beat moves on whenever the result register is free or emptying.
  assign advance  = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~s1_valid_q | advance;
  assign in_fire  = in_i.valid & in_i.ready;

  nvse_step u_step (
    .item_i   (s1_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{remembered_param: '0, slide_rate: '0, current_volume: '0,
                       slide_mode: nvse_pkg::SlideNone};
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.command      <= in_i.command;
      s1_item_q.effect_byte  <= in_i.effect_byte;
      s1_item_q.start_volume <= in_i.start_volume;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.volume         = result_q.volume;
  assign out_o.volume_written = result_q.volume_written;
  assign out_o.slide_active   = result_q.slide_active;

  a_vol_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.current_volume <= nvse_pkg::VolMax)
    else $error("channel volume above the upper limit");

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted beat not held in the input register");

  a_advance_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced beat produced no result");

  a_idle_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_item_q.command == nvse_pkg::CmdTick &&
    state_q.slide_mode == nvse_pkg::SlideNone |=> !result_q.volume_written)
    else $error("tick without a slide wrote the volume");

endmodule

### sv/nvse_step.sv
// Combinational update of the channel state for one beat.
// Decodes a note-on parameter or applies a tick, with clamping at 0 and 64.
// Depends on nvse_pkg.
module nvse_step (
  input  nvse_pkg::item_t   item_i,
  input  nvse_pkg::state_t  state_i,
  output nvse_pkg::state_t  state_o,
  output nvse_pkg::result_t result_o
);

  logic [nvse_pkg::ByteWidth-1:0] param;
  logic [nvse_pkg::NibWidth-1:0]  hi_nib;
  logic [nvse_pkg::NibWidth-1:0]  lo_nib;
  logic [nvse_pkg::VolWidth-1:0]  base_vol;
  logic [nvse_pkg::NibWidth-1:0]  rate;
  nvse_pkg::slide_mode_e          base_mode;
  logic                           do_rise;
  logic                           do_fall;
  logic [nvse_pkg::VolWidth:0]    rise_sum;
  logic [nvse_pkg::VolWidth-1:0]  rate_ext;
  logic [nvse_pkg::VolWidth-1:0]  vol_next;
  nvse_pkg::slide_mode_e          mode_next;

  assign param  = (item_i.effect_byte != '0) ? item_i.effect_byte : state_i.remembered_param;
  assign hi_nib = param[nvse_pkg::ByteWidth-1:nvse_pkg::NibWidth];
  assign lo_nib = param[nvse_pkg::NibWidth-1:0];

  always_comb begin
    base_vol  = state_i.current_volume;
    base_mode = state_i.slide_mode;
    rate      = state_i.slide_rate;
    do_rise   = 1'b0;
    do_fall   = 1'b0;
    unique case (item_i.command)
      nvse_pkg::CmdNoteOn: begin
        base_vol  = (item_i.start_volume > nvse_pkg::VolMax) ? nvse_pkg::VolMax
                                                             : item_i.start_volume;
        base_mode = nvse_pkg::SlideNone;
        priority if (lo_nib == nvse_pkg::NibZero) begin
          rate      = hi_nib;
          base_mode = nvse_pkg::SlideRise;
          do_rise   = (hi_nib == nvse_pkg::NibMax);
        end else if (hi_nib == nvse_pkg::NibZero) begin
          rate      = lo_nib;
          base_mode = nvse_pkg::SlideFall;
          do_fall   = (lo_nib == nvse_pkg::NibMax);
        end else if (lo_nib == nvse_pkg::NibMax) begin
          rate    = hi_nib;
          do_rise = 1'b1;
        end else if (hi_nib == nvse_pkg::NibMax) begin
          rate    = lo_nib;
          do_fall = 1'b1;
        end else begin
          rate = state_i.slide_rate;
        end
      end
      default: begin
        do_rise = (state_i.slide_mode == nvse_pkg::SlideRise);
        do_fall = (state_i.slide_mode == nvse_pkg::SlideFall);
      end
    endcase
  end

  assign rate_ext = {{(nvse_pkg::VolWidth-nvse_pkg::NibWidth){1'b0}}, rate};
  assign rise_sum = {1'b0, base_vol} + {1'b0, rate_ext};

  // Reaching either limit parks the volume there and ends the slide.
  always_comb begin
    vol_next  = base_vol;
    mode_next = base_mode;
    if (do_rise) begin
      if (rise_sum >= {1'b0, nvse_pkg::VolMax}) begin
        vol_next  = nvse_pkg::VolMax;
        mode_next = nvse_pkg::SlideNone;
      end else begin
        vol_next = rise_sum[nvse_pkg::VolWidth-1:0];
      end
    end else if (do_fall) begin
      if (base_vol <= rate_ext) begin
        vol_next  = '0;
        mode_next = nvse_pkg::SlideNone;
      end else begin
        vol_next = base_vol - rate_ext;
      end
    end
  end

  // A tick ignores its parameter byte, so only a note-on may change the remembered one.
  assign state_o.remembered_param = (item_i.command == nvse_pkg::CmdNoteOn)
                                    ? param : state_i.remembered_param;
  assign state_o.slide_rate       = rate;
  assign state_o.current_volume   = vol_next;
  assign state_o.slide_mode       = mode_next;

  assign result_o.volume         = vol_next;
  assign result_o.volume_written = do_rise | do_fall;
  assign result_o.slide_active   = mode_next;

endmodule

### sim/nvse_envelope_checker.sv
// Checker for the note volume slide envelope: watches both channels, predicts each result.
// Depends on nvse_pkg and the channel interfaces in nvse_if.sv.
`timescale 1ns / 1ps

module nvse_envelope_checker
  import nvse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  nvse_in_if          in_mon_i,
  nvse_out_if         out_mon_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  // Predicted channel state.
  logic [ByteWidth-1:0] memo_param;
  logic [NibWidth-1:0]  step_size;
  logic [VolWidth-1:0]  level;
  slide_mode_e          mode;

  result_t     expected_volumes[$];
  int unsigned mismatches;
  int unsigned pending;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = pending;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned wanted);
    $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, wanted);
    mismatches++;
  endtask

  task automatic rise_step();
    logic [VolWidth:0] sum;
    sum = {1'b0, level} + {{(VolWidth - NibWidth + 1){1'b0}}, step_size};
    if (sum >= {1'b0, VolMax}) begin
      level = VolMax;
      mode  = SlideNone;
    end else begin
      level = sum[VolWidth-1:0];
    end
  endtask

  task automatic fall_step();
    if (level <= {{(VolWidth - NibWidth){1'b0}}, step_size}) begin
      level = '0;
      mode  = SlideNone;
    end else begin
      level = level - {{(VolWidth - NibWidth){1'b0}}, step_size};
    end
  endtask

  task automatic envelope_predict(input item_t beat, output result_t res);
    logic [NibWidth-1:0] hi;
    logic [NibWidth-1:0] lo;
    logic                wrote;
    wrote = 1'b0;
    if (beat.command == CmdNoteOn) begin
      level = (beat.start_volume > VolMax) ? VolMax : beat.start_volume;
      mode  = SlideNone;
      if (beat.effect_byte != '0) memo_param = beat.effect_byte;
      hi = memo_param[ByteWidth-1:NibWidth];
      lo = memo_param[NibWidth-1:0];
      // The order of these tests matters: a byte with both nibbles at 15 is a single rise.
      if (lo == NibZero) begin
        step_size = hi;
        mode      = SlideRise;
        if (hi == NibMax) begin
          rise_step();
          wrote = 1'b1;
        end
      end else if (hi == NibZero) begin
        step_size = lo;
        mode      = SlideFall;
        if (lo == NibMax) begin
          fall_step();
          wrote = 1'b1;
        end
      end else if (lo == NibMax) begin
        step_size = hi;
        rise_step();
        wrote = 1'b1;
      end else if (hi == NibMax) begin
        step_size = lo;
        fall_step();
        wrote = 1'b1;
      end
    end else begin
      case (mode)
        SlideRise: begin
          rise_step();
          wrote = 1'b1;
        end
        SlideFall: begin
          fall_step();
          wrote = 1'b1;
        end
        default: ;
      endcase
    end
    res.volume         = level;
    res.volume_written = wrote;
    res.slide_active   = mode;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   beat;
    result_t got;
    result_t wanted;
    if (!rst_ni) begin
      memo_param = '0;
      step_size  = '0;
      level      = '0;
      mode       = SlideNone;
      expected_volumes.delete();
      pending    = 0;
      mismatches = 0;
    end else begin
      // Results are taken before new beats are predicted; a result never belongs to
      // a beat accepted at the same edge.
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.volume         = out_mon_i.volume;
        got.volume_written = out_mon_i.volume_written;
        got.slide_active   = out_mon_i.slide_active;
        if (expected_volumes.size() == 0) begin
          report_mismatch("result beat with nothing expected, volume", got.volume, 0);
        end else begin
          wanted = expected_volumes.pop_front();
          pending--;
          if (got.volume !== wanted.volume)
            report_mismatch("volume", got.volume, wanted.volume);
          if (got.volume_written !== wanted.volume_written)
            report_mismatch("volume_written", got.volume_written, wanted.volume_written);
          if (got.slide_active !== wanted.slide_active)
            report_mismatch("slide_active", got.slide_active, wanted.slide_active);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        beat.command      = in_mon_i.command;
        beat.effect_byte  = in_mon_i.effect_byte;
        beat.start_volume = in_mon_i.start_volume;
        envelope_predict(beat, wanted);
        expected_volumes.push_back(wanted);
        pending++;
      end
    end
  end

endmodule

### sim/note_volume_slide_envelope_tb.sv
// Top of the note volume slide envelope testbench: clock, reset, stimulus and verdict.
// Depends on nvse_pkg, nvse_if.sv, the block itself and nvse_envelope_checker.
`timescale 1ns / 1ps

module note_volume_slide_envelope_tb;
  import nvse_pkg::*;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned PhaseBeats   = 205;
  localparam int unsigned SettleCycles = 4;

  logic clk_i = 1'b0;
  logic rst_ni;

  nvse_in_if  in_ch ();
  nvse_out_if out_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 65;
  logic        long_stall_go = 1'b0;
  logic        long_stall_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  note_volume_slide_envelope dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  nvse_envelope_checker envelope_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (in_ch),
    .out_mon_i        (out_ch),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // Result side: random stalls, plus one long hold-off so that the block fills up.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (long_stall_go && !long_stall_taken) begin
      out_ch.ready     <= 1'b0;
      hold_left        <= LongHold;
      long_stall_taken <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("note_volume_slide_envelope regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_beat(input item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= beat.command;
    in_ch.effect_byte  <= beat.effect_byte;
    in_ch.start_volume <= beat.start_volume;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_note_on(input logic [ByteWidth-1:0] param,
                              input logic [VolWidth-1:0] start);
    item_t beat;
    beat.command      = CmdNoteOn;
    beat.effect_byte  = param;
    beat.start_volume = start;
    send_beat(beat);
  endtask

  // The parameter and start volume are ignored on a tick, so they carry noise.
  task automatic send_tick();
    item_t beat;
    beat.command      = CmdTick;
    beat.effect_byte  = ByteWidth'($urandom);
    beat.start_volume = VolWidth'($urandom);
    send_beat(beat);
  endtask

  // A note-on with a parameter of a random class, followed by a run of ticks.
  task automatic send_note_with_ticks(inout int unsigned sent);
    logic [ByteWidth-1:0] param;
    logic [VolWidth-1:0]  start;
    logic [NibWidth-1:0]  nib;
    int unsigned          ticks;
    nib   = NibWidth'($urandom);
    start = ($urandom_range(9) == 0) ? VolWidth'($urandom_range(127, 65))
                                     : VolWidth'($urandom_range(64));
    case ($urandom_range(6))
      0:       param = '0;
      1:       param = {nib, NibZero};
      2:       param = {NibZero, nib};
      3:       param = {nib, NibMax};
      4:       param = {NibMax, nib};
      default: param = ByteWidth'($urandom);
    endcase
    send_note_on(param, start);
    sent++;
    ticks = $urandom_range(12);
    repeat (ticks) begin
      send_tick();
      sent++;
    end
  endtask

  // Holds the input idle until every expected result has arrived.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CmdNoteOn;
    in_ch.effect_byte  <= '0;
    in_ch.start_volume <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats: limits, every decode branch and the clamps.
    send_tick();                   // no slide running yet
    send_note_on(8'h00, 7'd10);    // nothing remembered: rising slide of rate 0
    send_tick();
    send_note_on(8'h20, 7'd127);   // start volume saturates at 64
    send_tick();
    send_note_on(8'hF0, 7'd60);    // immediate rise clamps at 64
    send_note_on(8'h05, 7'd12);    // falling slide down to zero, then nothing
    repeat (4) send_tick();
    send_note_on(8'h0F, 7'd40);    // immediate fall that keeps sliding
    send_tick();
    send_note_on(8'h3F, 7'd20);    // single rise
    send_tick();
    send_note_on(8'hF4, 7'd2);     // single fall clamped at zero
    send_note_on(8'h57, 7'd33);    // plain load
    send_note_on(8'h00, 7'd50);    // reuses the remembered parameter
    send_note_on(8'hFF, 7'd0);     // both nibbles at 15 give a single rise
    send_note_on(8'h0F, 7'd0);
    send_note_on(8'hE0, 7'd65);
    send_tick();
    send_note_on(8'h01, 7'd1);
    send_tick();

    sent = 0;
    while (sent < PhaseBeats) begin
      if (sent >= 60 && !long_stall_go) long_stall_go <= 1'b1;
      send_note_with_ticks(sent);
    end
    wait_for_drain();

    send_idle_pct <= 65;
    recv_idle_pct <= 23;
    sent = 0;
    while (sent < PhaseBeats) send_note_with_ticks(sent);
    wait_for_drain();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    sent = 0;
    while (sent < PhaseBeats) send_note_with_ticks(sent);
    wait_for_drain();

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("note_volume_slide_envelope regression: pass");
    end else begin
      $display("note_volume_slide_envelope regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
sv/nvse_pkg.sv
sv/nvse_if.sv
sv/nvse_step.sv
sv/note_volume_slide_envelope.sv
sim/nvse_envelope_checker.sv
sim/note_volume_slide_envelope_tb.sv
